// ----- hdl/mbps_pkg.sv -----
// shared constants and types of the masked byte pattern search
`timescale 1ns / 1ps

package mbps_pkg;

    localparam int PATTERN_MAX    = 16;
    localparam int OFFSET_BITS    = 32;
    localparam int WINDOW_DEPTH   = 16;
    localparam int MATCH_OFF_BITS = 32;
    localparam int LEN_BITS       = 5;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 64;
    // offset arithmetic is done at the wider of the counter and the field
    localparam int EXT_BITS = (OFFSET_BITS > MATCH_OFF_BITS) ? OFFSET_BITS : MATCH_OFF_BITS;
    localparam int CAP_LEN  = (PATTERN_MAX > WINDOW_DEPTH) ? WINDOW_DEPTH : PATTERN_MAX;

    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LOW    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_HIGH   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CARE_MASK      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LENGTH = 3'd3;

    typedef struct packed {
        logic                      found;
        logic [MATCH_OFF_BITS-1:0] match_offset;
    } t_result;

endpackage

// ----- hdl/mbps_cell.sv -----
// one window cell: holds a recent byte, passes it on and compares its next value
`timescale 1ns / 1ps

module mbps_cell (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shift,
    input  logic       i_clear,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_pat_byte,
    input  logic       i_care,
    output logic [7:0] o_byte,
    output logic       o_hit
);

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_byte <= 8'd0;
        end else if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    // hit is judged on the byte this cell will hold after the shift
    assign o_hit  = !i_care || (i_byte == i_pat_byte);
    assign o_byte = r_byte;

endmodule

// ----- hdl/mbps_outq.sv -----
// two-entry result queue between the match logic and the output channel
`timescale 1ns / 1ps

module mbps_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mbps_pkg::t_result i_res,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_pop_ready,
    output mbps_pkg::t_result o_res
);

    logic [1:0]        r_count;
    logic [1:0]        n_count;
    mbps_pkg::t_result r_q0;
    mbps_pkg::t_result r_q1;
    logic              w_pop;

    assign w_pop   = (r_count != 2'd0) && i_pop_ready;
    assign o_valid = (r_count != 2'd0);
    assign o_room  = (r_count != 2'd2);
    assign o_res   = r_q0;

    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (i_push && r_count == 2'd1) begin
                r_q0 <= i_res;
            end else begin
                r_q0 <= r_q1;
            end
            if (i_push && r_count == 2'd2) begin
                r_q1 <= i_res;
            end
        end else if (i_push) begin
            if (r_count == 2'd0) begin
                r_q0 <= i_res;
            end else begin
                r_q1 <= i_res;
            end
        end
    end

endmodule

// ----- hdl/masked_byte_pattern_search.sv -----
// top level of the masked byte pattern search
`timescale 1ns / 1ps
// Searches a byte stream for the first place where a pattern of up to 16 bytes
// matches, with wildcard positions given by a care mask.
// Input channel: one byte per request in s_tdata, s_tlast marks the last byte
// of a region. Output channel: m_tdata carries the match start offset,
// m_tuser says found (1) or region ended without a match (0).
// Each region gives at most one result: found when the first full match ends,
// otherwise not found on the last byte. Bytes after a match are dropped until
// the last byte, which ends the region.
// Throughput: one byte per cycle while o_s_tready is high. All pattern positions
// are compared at once by a chain of window cells that shift on every accepted
// byte until a match is reported; results are registered in the output queue.
// Results wait in a two-entry queue; if the receiver stalls, input is still taken
// until both entries hold results, then o_s_tready drops. Configuration writes
// take effect at once and must be made while the block is idle; not enforced.
// Reset clears the window, byte count and queue; pattern registers go to zero,
// care mask to all ones, pattern length to one.

module masked_byte_pattern_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,   // last_byte
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] match_offset
    output logic        o_m_tuser,   // [0] found
    // configuration
    input  logic        i_cfg_we,
    input  logic [mbps_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [mbps_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int NC = mbps_pkg::PATTERN_MAX;
    localparam int OB = mbps_pkg::OFFSET_BITS;
    localparam int LB = mbps_pkg::LEN_BITS;
    localparam int XB = mbps_pkg::EXT_BITS;
    localparam logic [OB-1:0] COUNT_MAX = {OB{1'b1}};
    localparam logic [XB-1:0] FIELD_MAX = XB'({mbps_pkg::MATCH_OFF_BITS{1'b1}});

    logic [63:0]   r_pat_low;
    logic [63:0]   r_pat_high;
    logic [15:0]   r_care;
    logic [LB-1:0] r_len_raw;
    logic [OB-1:0] r_seen;
    logic          r_reported;

    logic [7:0]    w_pat [16];
    logic [LB-1:0] w_len;
    logic          w_accept;
    logic          w_shift;
    logic          w_clear;
    logic [OB-1:0] w_next_seen;
    logic [XB-1:0] w_start;
    logic          w_match;
    logic          w_push;
    logic [NC-1:0] w_hit;
    logic [7:0]    w_chain [NC+1];
    mbps_pkg::t_result w_res;
    mbps_pkg::t_result w_out;
    logic          w_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= 64'd0;
            r_pat_high <= 64'd0;
            r_care     <= 16'hFFFF;
            r_len_raw  <= LB'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mbps_pkg::REG_PATTERN_LOW:    r_pat_low  <= i_cfg_data;
                mbps_pkg::REG_PATTERN_HIGH:   r_pat_high <= i_cfg_data;
                mbps_pkg::REG_CARE_MASK:      r_care     <= i_cfg_data[15:0];
                mbps_pkg::REG_PATTERN_LENGTH: r_len_raw  <= i_cfg_data[LB-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            w_pat[b]     = r_pat_low[b*8 +: 8];
            w_pat[b + 8] = r_pat_high[b*8 +: 8];
        end
        if (r_len_raw == '0) begin
            w_len = LB'(1);
        end else if (r_len_raw > LB'(mbps_pkg::CAP_LEN)) begin
            w_len = LB'(mbps_pkg::CAP_LEN);
        end else begin
            w_len = r_len_raw;
        end
    end

    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_shift  = w_accept && !r_reported;
    assign w_clear  = w_accept && i_s_tlast;

    assign w_chain[0] = i_s_tdata;

    genvar k;
    generate
        for (k = 0; k < NC; k++) begin : g_cell
            logic [LB-1:0] w_idx;
            logic          w_used;
            assign w_used = (LB'(k) < w_len);
            assign w_idx  = w_len - LB'(1) - LB'(k);

            mbps_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_shift    (w_shift),
                .i_clear    (w_clear),
                .i_byte     (w_chain[k]),
                .i_pat_byte (w_pat[w_idx[3:0]]),
                .i_care     (w_used && r_care[w_idx[3:0]]),
                .o_byte     (w_chain[k+1]),
                .o_hit      (w_hit[k])
            );
        end
    endgenerate

    always_comb begin
        w_next_seen = (r_seen == COUNT_MAX) ? r_seen : r_seen + OB'(1);
        w_match     = (&w_hit) && (XB'(w_next_seen) >= XB'(w_len));
        w_start     = XB'(w_next_seen) - XB'(w_len);
        w_res.found = w_match;
        if (!w_match) begin
            w_res.match_offset = '0;
        end else if (w_start > FIELD_MAX) begin
            w_res.match_offset = '1;
        end else begin
            w_res.match_offset = w_start[mbps_pkg::MATCH_OFF_BITS-1:0];
        end
        w_push = w_shift && (w_match || i_s_tlast);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            r_seen     <= '0;
            r_reported <= 1'b0;
        end else if (w_shift) begin
            r_seen <= w_next_seen;
            if (w_match) begin
                r_reported <= 1'b1;
            end
        end
    end

    mbps_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_res       (w_res),
        .o_room      (w_room),
        .o_valid     (o_m_tvalid),
        .i_pop_ready (i_m_tready),
        .o_res       (w_out)
    );

    assign o_s_tready = w_room;
    assign o_m_tdata  = w_out.match_offset;
    assign o_m_tuser  = w_out.found;

endmodule
